@@ rtl/core/phu_pkg.sv @@
// ----------------------------------------------------------------------------
// phu_pkg: shared constants and helpers for the phase unwrapper
// Default widths, the pi constant at 48 fraction bits, and the functions that
// round it to the working fraction width.
// ----------------------------------------------------------------------------
package phu_pkg;

	localparam int IN_WIDTH_DEF  = 16;
	localparam int OUT_WIDTH_DEF = 24;
	localparam int FRAC_BITS_DEF = 12;

	// pi * 2^48, rounded
	localparam longint PI_Q48 = 64'h0003_243F_6A88_85A3;

	// pi rounded to frac_bits fraction bits
	function automatic longint pi_q(input int frac_bits);
		return (PI_Q48 + (longint'(1) << (47 - frac_bits))) >> (48 - frac_bits);
	endfunction

	// bits needed to hold 2*pi (and so any residue below it)
	function automatic int res_width(input int frac_bits);
		return $clog2(2 * pi_q(frac_bits) + 1);
	endfunction

endpackage

@@ rtl/core/phase_unwrap.sv @@
// Throughput: one beat per clock while the output is not stalled, held by
// updating the previous output and its residue together in the tracking
// stage.
// Reset clears all valid bits and marks the next sample as the first of a
// sequence; data registers are not reset.
// ----------------------------------------------------------------------------
// phase_unwrap: streaming phase unwrapper
// Reduces each wrapped phase sample modulo 2*pi, then shifts it by a whole
// multiple of 2*pi to land within pi of the previous output, saturating.
// ----------------------------------------------------------------------------
module phase_unwrap import phu_pkg::*; #(
	parameter int IN_WIDTH  = IN_WIDTH_DEF,
	parameter int OUT_WIDTH = OUT_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [IN_WIDTH-1:0]  phase_in,
	input  logic                        last_sample,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_WIDTH-1:0] phase_out,
	output logic                        saturated
);

	localparam int DW = res_width(FRAC_BITS);

	logic                       res_valid, res_stall, res_last;
	logic signed [IN_WIDTH-1:0] res_x;
	logic [DW-1:0]              res_xr;

	phu_residue #(
		.IN_WIDTH  (IN_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.DW        (DW)
	) u_residue (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.phase_in    (phase_in),
		.last_sample (last_sample),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.x           (res_x),
		.xr          (res_xr),
		.last        (res_last)
	);

	phu_track #(
		.IN_WIDTH  (IN_WIDTH),
		.OUT_WIDTH (OUT_WIDTH),
		.FRAC_BITS (FRAC_BITS),
		.DW        (DW)
	) u_track (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.x         (res_x),
		.xr        (res_xr),
		.last      (res_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.phase_out (phase_out),
		.saturated (saturated)
	);

endmodule

@@ rtl/core/phu_residue.sv @@
// ----------------------------------------------------------------------------
// phu_residue: input phase modulo 2*pi
// Four-stage pipeline that registers the input beat and reduces it modulo
// 2*pi through a reciprocal multiply, a constant multiply and two folds.
// ----------------------------------------------------------------------------
module phu_residue import phu_pkg::*; #(
	parameter int IN_WIDTH  = IN_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DW        = res_width(FRAC_BITS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [IN_WIDTH-1:0]  phase_in,
	input  logic                        last_sample,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic signed [IN_WIDTH-1:0]  x,
	output logic [DW-1:0]               xr,
	output logic                        last
);

	localparam longint PI_L = pi_q(FRAC_BITS);
	localparam longint D_L  = 2 * PI_L;
	localparam int     RW   = DW + 1;
	localparam int     S    = IN_WIDTH + DW;
	localparam int     MW   = IN_WIDTH + 1;
	localparam int     PW   = IN_WIDTH + MW;
	localparam int     QW   = (IN_WIDTH - DW + 1 > 1) ? IN_WIDTH - DW + 1 : 1;
	localparam int     EW   = (IN_WIDTH > DW) ? IN_WIDTH + 1 : DW + 1;
	localparam longint M_L  = (longint'(1) << S) / D_L;
	localparam longint C_L  = (longint'(1) << (IN_WIDTH - 1)) % D_L;

	localparam logic [MW-1:0] M_V  = MW'(M_L);
	localparam logic [EW-1:0] D_E  = EW'(D_L);
	localparam logic [RW-1:0] D_R  = RW'(D_L);
	localparam logic [RW-1:0] D2_R = RW'(2 * D_L);
	localparam logic [RW-1:0] C_R  = RW'(C_L);
	localparam logic [RW-1:0] DC_R = RW'(D_L - C_L);

	logic                       v_s1, v_s2, v_s3, v_s4;
	logic                       en1, en2, en3, en4;
	logic signed [IN_WIDTH-1:0] x_s1, x_s2, x_s3, x_s4;
	logic                       last_s1, last_s2, last_s3, last_s4;
	logic [PW-1:0]              prod_s2;
	logic [RW-1:0]              rem0_s3;
	logic [DW-1:0]              xr_s4;

	logic [IN_WIDTH-1:0]        u1, u2;
	logic [PW-1:0]              prod_c, prod_sh;
	logic [QW-1:0]              q_c;
	logic [EW-1:0]              qd_c, rem_c;
	logic [RW-1:0]              rem1_c, xr_c;

	assign en4      = !v_s4 || !res_stall;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	// offset binary so the reduction works on an unsigned value
	assign u1 = {~x_s1[IN_WIDTH-1], x_s1[IN_WIDTH-2:0]};
	assign u2 = {~x_s2[IN_WIDTH-1], x_s2[IN_WIDTH-2:0]};

	assign prod_c = PW'(u1) * PW'(M_V);

	// quotient estimate is exact or one low
	assign prod_sh = prod_s2 >> S;
	assign q_c     = prod_sh[QW-1:0];
	assign qd_c    = EW'(q_c) * D_E;
	assign rem_c   = EW'(u2) - qd_c;

	// fold into [0, 2pi) and remove the offset-binary bias
	assign rem1_c = (rem0_s3 >= D_R) ? rem0_s3 - D_R : rem0_s3;
	assign xr_c   = (rem1_c >= C_R) ? rem1_c - C_R : rem1_c + DC_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			x_s1    <= phase_in;
			last_s1 <= last_sample;
		end
		if (en2) begin
			x_s2    <= x_s1;
			last_s2 <= last_s1;
			prod_s2 <= prod_c;
		end
		if (en3) begin
			x_s3    <= x_s2;
			last_s3 <= last_s2;
			rem0_s3 <= rem_c[RW-1:0];
		end
		if (en4) begin
			x_s4    <= x_s3;
			last_s4 <= last_s3;
			xr_s4   <= xr_c[DW-1:0];
		end
	end

	assign res_valid = v_s4;
	assign x         = x_s4;
	assign xr        = xr_s4;
	assign last      = last_s4;

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> rem0_s3 < D2_R)
		else $error("reduction remainder not below 4*pi");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> {1'b0, xr_s4} < D_R)
		else $error("residue not below 2*pi");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (v_s1 && v_s2 && v_s3 && v_s4 && res_stall))
		else $error("input stalled with room in the pipeline");

endmodule

@@ rtl/core/phu_track.sv @@
// ----------------------------------------------------------------------------
// phu_track: unwrap against the previous output
// Keeps the previous output and its residue modulo 2*pi, picks the step that
// lands within pi of it, saturates and holds the result beat.
// ----------------------------------------------------------------------------
module phu_track import phu_pkg::*; #(
	parameter int IN_WIDTH  = IN_WIDTH_DEF,
	parameter int OUT_WIDTH = OUT_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DW        = res_width(FRAC_BITS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        res_valid,
	output logic                        res_stall,
	input  logic signed [IN_WIDTH-1:0]  x,
	input  logic [DW-1:0]               xr,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [OUT_WIDTH-1:0] phase_out,
	output logic                        saturated
);

	localparam longint PI_L   = pi_q(FRAC_BITS);
	localparam longint D_L    = 2 * PI_L;
	localparam int     RW     = DW + 1;
	localparam int     MX     = (IN_WIDTH > OUT_WIDTH) ? IN_WIDTH : OUT_WIDTH;
	localparam int     LW     = ((MX > DW) ? MX : DW) + 2;
	localparam longint OMAX_L = (longint'(1) << (OUT_WIDTH - 1)) - 1;
	localparam longint OMIN_L = -OMAX_L - 1;
	localparam longint RMAX_L = OMAX_L % D_L;
	localparam longint RMIN_L = ((OMIN_L % D_L) + D_L) % D_L;

	localparam logic [RW-1:0]        D_R    = RW'(D_L);
	localparam logic [RW-1:0]        PI_R   = RW'(PI_L);
	localparam logic signed [LW-1:0] PI_S   = LW'(PI_L);
	localparam logic signed [LW-1:0] D_S    = LW'(D_L);
	localparam logic signed [LW-1:0] OMAX_S = LW'(OMAX_L);
	localparam logic signed [LW-1:0] OMIN_S = LW'(OMIN_L);
	localparam logic [DW-1:0]        RMAX_V = DW'(RMAX_L);
	localparam logic [DW-1:0]        RMIN_V = DW'(RMIN_L);

	logic                        out_valid_q, saturated_q, have_prev_q;
	logic signed [OUT_WIDTH-1:0] phase_out_q;
	logic [DW-1:0]               rho_q;

	logic                        ld;
	logic signed [LW-1:0]        xe, pe, d, r, y, y_c;
	logic [RW-1:0]               tt, t;
	logic                        sat;
	logic [DW-1:0]               rho_n;

	assign res_stall = out_valid_q && out_stall;
	assign ld        = res_valid && !res_stall;

	// the output register doubles as the previous-output state
	assign xe = LW'(x);
	assign pe = LW'(phase_out_q);
	assign d  = xe - pe;

	// (x - prev) mod 2pi from the two residues
	assign tt = {1'b0, xr} - {1'b0, rho_q};
	assign t  = tt[RW-1] ? tt + D_R : tt;

	always_comb begin
		if (t < PI_R) begin
			r = LW'(t);
		end else if (t > PI_R) begin
			r = LW'(t) - D_S;
		end else if (d == PI_S) begin
			// distance exactly pi: one step toward prev
			r = -PI_S;
		end else if (d == -PI_S) begin
			r = PI_S;
		end else if (d[LW-1]) begin
			r = -PI_S;
		end else begin
			r = PI_S;
		end
	end

	assign y = have_prev_q ? pe + r : xe;

	always_comb begin
		if (y > OMAX_S) begin
			y_c   = OMAX_S;
			sat   = 1'b1;
			rho_n = RMAX_V;
		end else if (y < OMIN_S) begin
			y_c   = OMIN_S;
			sat   = 1'b1;
			rho_n = RMIN_V;
		end else begin
			y_c   = y;
			sat   = 1'b0;
			rho_n = xr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			if (ld) begin
				out_valid_q <= 1'b1;
				have_prev_q <= !last;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			phase_out_q <= y_c[OUT_WIDTH-1:0];
			saturated_q <= sat;
			rho_q       <= rho_n;
		end
	end

	assign out_valid = out_valid_q;
	assign phase_out = phase_out_q;
	assign saturated = saturated_q;

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && saturated_q) |-> (pe == OMAX_S || pe == OMIN_S))
		else $error("saturated beat not on a rail");

	a_seq_flag: assert property (@(posedge clk) disable iff (!arst_n)
		ld |=> (out_valid_q && (have_prev_q == !$past(last))))
		else $error("sequence flag or result valid not updated on load");

	a_within_pi: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && have_prev_q && !sat) |=>
			((pe - $past(pe) <= PI_S) && (pe - $past(pe) >= -PI_S)))
		else $error("unwrapped step larger than pi");

endmodule

@@ test/phase_unwrap_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_unwrap_tb: self-checking bench for the streaming phase unwrapper
// Drives directed corner samples and then random sequences: a steep ramp long
// enough to clip at the top, smooth walks, large jumps and noise. Each
// result beat is checked against an in-bench unwrap predictor. Both sides
// idle in random bursts.
// ----------------------------------------------------------------------------
module phase_unwrap_tb import phu_pkg::*; ();

	localparam int     IW           = IN_WIDTH_DEF;
	localparam int     OW           = OUT_WIDTH_DEF;
	localparam longint PI_FX        = 12868;	// round(pi * 2^12)
	localparam longint TWO_PI_FX    = 2 * PI_FX;
	localparam longint IN_HI        = (longint'(1) << (IW - 1)) - 1;
	localparam longint IN_LO        = -IN_HI - 1;
	localparam longint OUT_HI       = (longint'(1) << (OW - 1)) - 1;
	localparam longint OUT_LO       = -OUT_HI - 1;
	localparam int     CYCLE_LIMIT  = 200000;
	localparam int     DRAIN_CYCLES = 12;
	localparam int     CALM_TAIL    = 150;
	localparam int     RAMP_LEN     = 700;
	localparam int     MIXED_ITEMS  = 30;

	typedef struct packed {
		logic signed [IW-1:0] phase;
		logic                 last;
	} sample_t;

	typedef struct packed {
		logic signed [OW-1:0] phase;
		logic                 sat;
	} unwrapped_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic signed [IW-1:0] phase_in = '0;
	logic                 last_sample = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic signed [OW-1:0] phase_out;
	logic                 saturated;

	sample_t    sample_q[$];
	unwrapped_t unwrapped_q[$];
	sample_t    next_sample;
	unwrapped_t want;

	// predictor state
	longint track_phase = 0;
	bit     track_open = 1'b0;

	logic [31:0] cycle_cnt = '0;
	bit          gen_done = 1'b0;
	int          send_gap = 0;
	int          stall_left = 0;
	int          n_fail = 0;
	int          n_checked = 0;
	int          n_sat = 0;
	int          n_seq = 0;

	phase_unwrap u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.phase_in   (phase_in),
		.last_sample(last_sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.phase_out  (phase_out),
		.saturated  (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				unwrapped_q.size());
			$display("FAIL phase_unwrap");
			$finish;
		end
	end

	// quiet stretch whenever cycle_cnt bits 7:6 are both set, and none near the end
	function automatic bit idle_ok();
		return cycle_cnt[7:6] != 2'b11 && !(gen_done && sample_q.size() < CALM_TAIL);
	endfunction

	// shift by whole turns to land within pi of the last output, then clip
	function automatic unwrapped_t unwrap_next(sample_t s);
		longint     x;
		longint     d;
		longint     mag;
		longint     k;
		longint     y;
		unwrapped_t r;
		x = s.phase;
		y = x;
		if (track_open) begin
			d = x - track_phase;
			mag = (d < 0) ? -d : d;
			if (mag >= PI_FX) begin
				k = (mag - PI_FX + TWO_PI_FX - 1) / TWO_PI_FX;
				if (k < 1)
					k = 1;
				y = (d > 0) ? x - k * TWO_PI_FX : x + k * TWO_PI_FX;
			end
		end
		r.sat = 1'b0;
		if (y > OUT_HI) begin
			y = OUT_HI;
			r.sat = 1'b1;
		end else if (y < OUT_LO) begin
			y = OUT_LO;
			r.sat = 1'b1;
		end
		r.phase = y[OW-1:0];
		track_phase = y;
		track_open = !s.last;
		if (r.sat)
			n_sat++;
		if (s.last)
			n_seq++;
		return r;
	endfunction

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			phase_in <= '0;
			last_sample <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				unwrapped_q.push_back(unwrap_next({phase_in, last_sample}));
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (sample_q.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					next_sample = sample_q.pop_front();
					in_valid <= 1'b1;
					phase_in <= next_sample.phase;
					last_sample <= next_sample.last;
					if (idle_ok() && $urandom_range(0, 5) == 0)
						send_gap = $urandom_range(1, 3);
				end
			end
		end
	end

	// receiver stall bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_ok() && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (unwrapped_q.size() == 0) begin
				$error("unexpected result beat: phase_out %0d saturated %0b",
					phase_out, saturated);
				n_fail++;
			end else begin
				want = unwrapped_q.pop_front();
				n_checked++;
				if (phase_out !== want.phase) begin
					$error("phase_out: expected %0d, got %0d", want.phase, phase_out);
					n_fail++;
				end
				if (saturated !== want.sat) begin
					$error("saturated: expected %0b, got %0b", want.sat, saturated);
					n_fail++;
				end
			end
		end
	end

	task automatic push_sample(input longint phase, input bit last);
		sample_t s;
		s.phase = phase[IW-1:0];
		s.last = last;
		sample_q.push_back(s);
	endtask

	// wrap a true angle into the input range, sometimes one turn off center
	function automatic longint wrap_phase(longint t);
		longint r;
		longint alt;
		r = t % TWO_PI_FX;
		if (r < 0)
			r += TWO_PI_FX;
		if (r >= PI_FX)
			r -= TWO_PI_FX;
		alt = r + (longint'($urandom_range(0, 2)) - 1) * TWO_PI_FX;
		if (alt >= IN_LO && alt <= IN_HI)
			r = alt;
		return r;
	endfunction

	// dir: +1 up, -1 down, 0 random per step
	task automatic push_walk(input int len, input int step_lo, input int step_hi, input int dir);
		longint t;
		int     step;
		t = longint'($urandom_range(0, 65535)) - 32768;
		for (int i = 0; i < len; i++) begin
			push_sample(wrap_phase(t), i == len - 1);
			step = $urandom_range(step_lo, step_hi);
			if (dir < 0 || (dir == 0 && $urandom_range(0, 1)))
				t -= step;
			else
				t += step;
		end
	endtask

	task automatic push_noise(input int len);
		for (int i = 0; i < len; i++)
			push_sample(longint'($signed(IW'($urandom))), i == len - 1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (sample_q.size() != 0 || in_valid || unwrapped_q.size() != 0);
	endtask

	initial begin
		int n_mixed;
		int len;
		n_mixed = 0;

		// single-sample sequences at the input extremes
		push_sample(IN_HI, 1'b1);
		push_sample(IN_LO, 1'b1);
		// distance exactly pi steps a full turn, repeatedly; then a two-turn step
		push_sample(0, 1'b0);
		push_sample(PI_FX, 1'b0);
		push_sample(0, 1'b0);
		push_sample(-PI_FX, 1'b0);
		push_sample(PI_FX - 1, 1'b0);
		push_sample(IN_LO, 1'b1);
		// exactly -pi, just under pi, then a large positive jump
		push_sample(0, 1'b0);
		push_sample(-PI_FX, 1'b0);
		push_sample(PI_FX - 1, 1'b0);
		push_sample(IN_HI, 1'b0);
		push_sample(IN_LO, 1'b1);
		// opposite extremes back to back: three turns in one sample
		push_sample(IN_LO, 1'b0);
		push_sample(IN_HI, 1'b0);
		push_sample(IN_LO, 1'b0);
		push_sample(0, 1'b1);
		push_sample(-1, 1'b1);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// hold off until the directed beats have all come back
		wait_drained();

		// ramp just under pi per sample, long enough to clip at the top
		push_walk(RAMP_LEN, 12400, int'(PI_FX - 1), 1);
		while (n_mixed < MIXED_ITEMS) begin
			len = $urandom_range(1, 30);
			case ($urandom_range(0, 4))
				0: push_noise(len);
				1: push_walk(len, 0, 40000, 0);
				default: push_walk(len, 0, int'(PI_FX - 1), 0);
			endcase
			n_mixed += len;
		end
		gen_done = 1'b1;

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("checked %0d results over %0d sequences, %0d clipped", n_checked, n_seq,
			n_sat);
		$display("covered pi-distance steps, multi-turn jumps and clipping at the top rail");
		if (n_fail == 0)
			$display("PASS phase_unwrap");
		else
			$display("FAIL phase_unwrap");
		$finish;
	end

endmodule
